>>> design/sine_cosine_taylor_series_macros.svh
// Assertion macros shared by the sine/cosine block.
`ifndef SINE_COSINE_TAYLOR_SERIES_MACROS_SVH
`define SINE_COSINE_TAYLOR_SERIES_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define SCT_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define SCT_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> design/sct_pkg.sv
// Types, formats and constant tables of the sine/cosine block.
package sct_pkg;

   localparam int ANGLE_W  = 32;          // Q8.24 input angle
   localparam int VALUE_W  = 32;          // Q2.30 result
   localparam int FRAC_W   = 30;          // Q30 fraction bits
   localparam int HALF_Q30 = 1 << (FRAC_W - 1);

   // angle reduction
   localparam int RED_W      = 34;
   localparam int Q_W        = 7;         // turn count estimate, signed
   localparam int FOLD_K_W   = 14;
   localparam int FOLD_SHIFT = 40;
   localparam logic [FOLD_K_W-1:0] FOLD_K = 14'd10430;   // round(2^16 / two pi)
   localparam logic signed [RED_W-1:0] PI_Q24     = 34'sd52707179;
   localparam logic signed [RED_W-1:0] TWO_PI_Q24 = 34'sd105414357;

   // series datapath widths (magnitudes)
   localparam int X_MAG_W  = 26;          // |folded angle| in Q24
   localparam int XQ_SHIFT = 6;           // Q24 -> Q30
   localparam int XQ_W     = X_MAG_W + XQ_SHIFT;
   localparam int X2_W     = 34;          // x squared, Q30, up to pi^2
   localparam int TERM_W   = 33;          // largest term is about 5.2
   localparam int P1_W     = 36;          // term times x squared, up to about 51
   localparam int RECIP_W  = 30;
   localparam int SUM_W    = 36;          // signed running sum

   localparam logic [TERM_W-1:0] ONE_Q30 = TERM_W'(1) << FRAC_W;

   localparam int MAX_TERMS = 8;
   localparam int IDX_W     = $clog2(2 * MAX_TERMS);

   // 1/(n*(n+1)) in Q30 for n = 1..16
   localparam logic [RECIP_W-1:0] RECIP_TAB [2*MAX_TERMS] = '{
      30'd536870912, 30'd178956971, 30'd89478485,  30'd53687091,
      30'd35791394,  30'd25565282,  30'd19173961,  30'd14913081,
      30'd11930465,  30'd9761289,   30'd8134408,   30'd6882960,
      30'd5899680,   30'd5113056,   30'd4473924,   30'd3947580
   };

   // data handed from cell to cell
   typedef struct packed {
      logic                     op;
      logic [X2_W-1:0]          x2;
      logic                     term_neg;
      logic [TERM_W-1:0]        term_mag;
      logic signed [SUM_W-1:0]  sum;       // sum of the terms before this one
   } sct_lane_type;

endpackage

>>> design/sct_if.sv
// Request and response channel interfaces of the sine/cosine block.
interface sct_req_if import sct_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic                       op;
   logic signed [ANGLE_W-1:0]  angle;

   modport source (output valid, output op, output angle, input ready);
   modport sink   (input valid, input op, input angle, output ready);
endinterface

interface sct_rsp_if import sct_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [VALUE_W-1:0]  value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

>>> design/sct_fold.sv
// Angle folding into [-pi, pi], Q30 conversion and squaring (four stages).
module sct_fold import sct_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  logic                       in_op,
   input  logic signed [ANGLE_W-1:0]  in_angle,
   output logic                       dn_valid,
   input  logic                       dn_ready,
   output sct_lane_type               dn_data
);

   // windows: positive angles land in [pi-2pi+1, pi], negative in [-pi, -pi+2pi-1]
   localparam logic signed [RED_W-1:0] HI_LO = PI_Q24 - TWO_PI_Q24 + RED_W'(1);
   localparam logic signed [RED_W-1:0] HI_HI = PI_Q24;
   localparam logic signed [RED_W-1:0] LO_LO = -PI_Q24;
   localparam logic signed [RED_W-1:0] LO_HI = TWO_PI_Q24 - PI_Q24 - RED_W'(1);

   function automatic logic in_window(input logic signed [RED_W-1:0] c,
                                      input logic signed [RED_W-1:0] lo_b,
                                      input logic signed [RED_W-1:0] hi_b);
      return (c >= lo_b) && (c <= hi_b);
   endfunction

   // stage 1: turn estimate
   logic                              s1_valid_ff, s1_valid_in;
   logic                              s1_op_ff, s1_op_in;
   logic signed [ANGLE_W-1:0]         s1_x_ff, s1_x_in;
   logic signed [Q_W-1:0]             s1_q_ff, s1_q_in;
   logic signed [ANGLE_W+FOLD_K_W:0]  prod_k;
   // stage 2: remainder
   logic                              s2_valid_ff, s2_valid_in;
   logic                              s2_op_ff, s2_op_in;
   logic signed [ANGLE_W-1:0]         s2_x_ff, s2_x_in;
   logic signed [RED_W-1:0]           s2_r_ff, s2_r_in;
   logic                              s2_hi_ff, s2_hi_in;
   logic                              s2_lo_ff, s2_lo_in;
   // stage 3: window select and magnitude
   logic                              s3_valid_ff, s3_valid_in;
   logic                              s3_op_ff, s3_op_in;
   logic [X_MAG_W-1:0]                s3_mag_ff, s3_mag_in;
   logic                              s3_neg_ff, s3_neg_in;
   logic signed [RED_W-1:0]           cand_p, cand_m, folded, folded_abs;
   logic signed [RED_W-1:0]           win_lo, win_hi;
   // stage 4: square
   logic                              s4_valid_ff, s4_valid_in;
   sct_lane_type                      s4_data_ff, s4_data_in;
   logic [XQ_W-1:0]                   xq_mag;
   logic [2*XQ_W-1:0]                 sq, sq_rnd;

   logic s1_adv, s2_adv, s3_adv, s4_adv;

   assign s4_adv   = !s4_valid_ff || dn_ready;
   assign s3_adv   = !s3_valid_ff || s4_adv;
   assign s2_adv   = !s2_valid_ff || s3_adv;
   assign s1_adv   = !s1_valid_ff || s2_adv;
   assign in_ready = s1_adv;
   assign dn_valid = s4_valid_ff;
   assign dn_data  = s4_data_ff;

   always_comb begin
      prod_k      = in_angle * $signed({1'b0, FOLD_K});
      s1_valid_in = s1_adv ? in_valid : s1_valid_ff;
      s1_op_in    = s1_adv ? in_op : s1_op_ff;
      s1_x_in     = s1_adv ? in_angle : s1_x_ff;
      s1_q_in     = s1_adv ? prod_k[FOLD_SHIFT +: Q_W] : s1_q_ff;
   end

   always_comb begin
      s2_valid_in = s2_adv ? s1_valid_ff : s2_valid_ff;
      s2_op_in    = s2_adv ? s1_op_ff : s2_op_ff;
      s2_x_in     = s2_adv ? s1_x_ff : s2_x_ff;
      s2_r_in     = s2_adv ? RED_W'(s1_x_ff) - RED_W'(s1_q_ff) * TWO_PI_Q24 : s2_r_ff;
      s2_hi_in    = s2_adv ? (RED_W'(s1_x_ff) > PI_Q24) : s2_hi_ff;
      s2_lo_in    = s2_adv ? (RED_W'(s1_x_ff) < -PI_Q24) : s2_lo_ff;
   end

   always_comb begin
      cand_p = s2_r_ff + TWO_PI_Q24;
      cand_m = s2_r_ff - TWO_PI_Q24;
      win_lo = s2_hi_ff ? HI_LO : LO_LO;
      win_hi = s2_hi_ff ? HI_HI : LO_HI;
      if (!s2_hi_ff && !s2_lo_ff) begin
         folded = RED_W'(s2_x_ff);
      end else if (in_window(s2_r_ff, win_lo, win_hi)) begin
         folded = s2_r_ff;
      end else if (in_window(cand_p, win_lo, win_hi)) begin
         folded = cand_p;
      end else begin
         folded = cand_m;
      end
      folded_abs  = folded[RED_W-1] ? -folded : folded;
      s3_valid_in = s3_adv ? s2_valid_ff : s3_valid_ff;
      s3_op_in    = s3_adv ? s2_op_ff : s3_op_ff;
      s3_mag_in   = s3_adv ? folded_abs[X_MAG_W-1:0] : s3_mag_ff;
      s3_neg_in   = s3_adv ? folded[RED_W-1] : s3_neg_ff;
   end

   always_comb begin
      xq_mag      = {s3_mag_ff, {XQ_SHIFT{1'b0}}};
      sq          = (2*XQ_W)'(xq_mag) * (2*XQ_W)'(xq_mag);
      sq_rnd      = sq + (2*XQ_W)'(HALF_Q30);
      s4_valid_in = s4_adv ? s3_valid_ff : s4_valid_ff;
      s4_data_in  = s4_data_ff;
      if (s4_adv) begin
         s4_data_in.op       = s3_op_ff;
         s4_data_in.x2       = sq_rnd[FRAC_W +: X2_W];
         s4_data_in.term_neg = s3_op_ff ? 1'b0 : s3_neg_ff;
         s4_data_in.term_mag = s3_op_ff ? ONE_Q30 : TERM_W'(xq_mag);
         s4_data_in.sum      = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
         s4_valid_ff <= s4_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_op_ff   <= s1_op_in;
      s1_x_ff    <= s1_x_in;
      s1_q_ff    <= s1_q_in;
      s2_op_ff   <= s2_op_in;
      s2_x_ff    <= s2_x_in;
      s2_r_ff    <= s2_r_in;
      s2_hi_ff   <= s2_hi_in;
      s2_lo_ff   <= s2_lo_in;
      s3_op_ff   <= s3_op_in;
      s3_mag_ff  <= s3_mag_in;
      s3_neg_ff  <= s3_neg_in;
      s4_data_ff <= s4_data_in;
   end

endmodule

>>> design/sct_cell.sv
// One series cell: adds the incoming term and forms the next one (two stages).
module sct_cell import sct_pkg::*; #(
   parameter int K = 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          up_valid,
   output logic          up_ready,
   input  sct_lane_type  up_data,
   output logic          dn_valid,
   input  logic          dn_ready,
   output sct_lane_type  dn_data
);

   // reciprocal of n*(n+1): n = 2K for sine, 2K-1 for cosine
   localparam logic [IDX_W-1:0] SIN_IDX = IDX_W'(2 * K - 1);
   localparam logic [IDX_W-1:0] COS_IDX = IDX_W'(2 * K - 2);
   localparam int PROD1_W = TERM_W + X2_W;
   localparam int PROD2_W = P1_W + RECIP_W;

   logic                     a_valid_ff, a_valid_in;
   logic                     a_op_ff, a_op_in;
   logic [X2_W-1:0]          a_x2_ff, a_x2_in;
   logic                     a_neg_ff, a_neg_in;
   logic [P1_W-1:0]          a_p1_ff, a_p1_in;
   logic signed [SUM_W-1:0]  a_sum_ff, a_sum_in;
   logic                     b_valid_ff, b_valid_in;
   sct_lane_type             b_data_ff, b_data_in;

   logic [PROD1_W-1:0]       prod1, rnd1;
   logic [PROD2_W-1:0]       prod2, rnd2;
   logic [SUM_W-1:0]         mag_ext;
   logic signed [SUM_W-1:0]  term_s;
   logic [RECIP_W-1:0]       recip;
   logic                     a_adv, b_adv;

   assign b_adv    = !b_valid_ff || dn_ready;
   assign a_adv    = !a_valid_ff || b_adv;
   assign up_ready = a_adv;
   assign dn_valid = b_valid_ff;
   assign dn_data  = b_data_ff;

   // stage a: term times x squared, running sum takes the incoming term
   always_comb begin
      prod1      = PROD1_W'(up_data.term_mag) * PROD1_W'(up_data.x2);
      rnd1       = prod1 + PROD1_W'(HALF_Q30);
      mag_ext    = SUM_W'(up_data.term_mag);
      term_s     = up_data.term_neg ? -$signed(mag_ext) : $signed(mag_ext);
      a_valid_in = a_adv ? up_valid : a_valid_ff;
      a_op_in    = a_adv ? up_data.op : a_op_ff;
      a_x2_in    = a_adv ? up_data.x2 : a_x2_ff;
      a_neg_in   = a_adv ? up_data.term_neg : a_neg_ff;
      a_p1_in    = a_adv ? rnd1[FRAC_W +: P1_W] : a_p1_ff;
      a_sum_in   = a_adv ? up_data.sum + term_s : a_sum_ff;
   end

   // stage b: times the reciprocal, sign flips
   always_comb begin
      recip      = a_op_ff ? RECIP_TAB[COS_IDX] : RECIP_TAB[SIN_IDX];
      prod2      = PROD2_W'(a_p1_ff) * PROD2_W'(recip);
      rnd2       = prod2 + PROD2_W'(HALF_Q30);
      b_valid_in = b_adv ? a_valid_ff : b_valid_ff;
      b_data_in  = b_data_ff;
      if (b_adv) begin
         b_data_in.op       = a_op_ff;
         b_data_in.x2       = a_x2_ff;
         b_data_in.term_neg = !a_neg_ff;
         b_data_in.term_mag = rnd2[FRAC_W +: TERM_W];
         b_data_in.sum      = a_sum_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      a_op_ff   <= a_op_in;
      a_x2_ff   <= a_x2_in;
      a_neg_ff  <= a_neg_in;
      a_p1_ff   <= a_p1_in;
      a_sum_ff  <= a_sum_in;
      b_data_ff <= b_data_in;
   end

endmodule

>>> design/sine_cosine_taylor_series.sv
// Top level of the Taylor series sine/cosine block.
//
// Usage:
//   req_bus carries one beat per angle: op selects sine (0) or cosine (1),
//   angle is signed Q8.24 radians. rsp_bus returns one beat per request,
//   value in signed Q2.30, in request order.
// Pipeline: four folding/squaring stages, two stages per series cell, one
//   output register.
// Throughput: one beat per cycle while rsp_bus.ready stays high, set by the
//   fully pipelined cell row; every cell owns its own pair of multipliers.
// Reset: synchronous, clears every stage valid; nothing else is held.
// Stall: a stage moves only when the one after it is empty or moving, so
//   while the receiver holds rsp_bus.ready low, requests are still taken
//   until every bubble in the pipe is filled; req_bus.ready drops only when
//   all stages hold data.
// Sums outside the 32-bit range saturate.
`include "sine_cosine_taylor_series_macros.svh"

module sine_cosine_taylor_series import sct_pkg::*; #(
   parameter int TERMS = 4
) (
   input  logic        clock,
   input  logic        reset,
   sct_req_if.sink     req_bus,
   sct_rsp_if.source   rsp_bus
);

   // series length, capped at the size of the reciprocal table
   localparam int N_CELLS = (TERMS > MAX_TERMS) ? MAX_TERMS : TERMS;

   // saturation bounds in the widened sum format
   localparam logic signed [SUM_W:0] SAT_HI =
      {{(SUM_W - VALUE_W + 2){1'b0}}, {(VALUE_W - 1){1'b1}}};
   localparam logic signed [SUM_W:0] SAT_LO = ~SAT_HI;

   // lane k is the output of cell k; lane 0 comes from the folding front end
   logic [N_CELLS:0]   lane_valid;
   logic [N_CELLS:0]   lane_ready;
   sct_lane_type       lane_data [N_CELLS+1];

   logic                        out_valid_ff, out_valid_in;
   logic signed [VALUE_W-1:0]   value_ff, value_in;
   logic [SUM_W-1:0]            last_mag;
   logic signed [SUM_W-1:0]     last_term;
   logic signed [SUM_W:0]       total;
   logic                        out_adv;

   sct_fold u_fold (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_bus.valid),
      .in_ready (req_bus.ready),
      .in_op    (req_bus.op),
      .in_angle (req_bus.angle),
      .dn_valid (lane_valid[0]),
      .dn_ready (lane_ready[0]),
      .dn_data  (lane_data[0])
   );

   // row of series cells, cell k forms term k
   for (genvar k = 1; k <= N_CELLS; k++) begin : g_cell
      sct_cell #(.K(k)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .up_valid (lane_valid[k-1]),
         .up_ready (lane_ready[k-1]),
         .up_data  (lane_data[k-1]),
         .dn_valid (lane_valid[k]),
         .dn_ready (lane_ready[k]),
         .dn_data  (lane_data[k])
      );
   end

   // output stage: add the last term, saturate, hold for the receiver
   assign out_adv              = !out_valid_ff || rsp_bus.ready;
   assign lane_ready[N_CELLS]  = out_adv;

   always_comb begin
      last_mag     = SUM_W'(lane_data[N_CELLS].term_mag);
      last_term    = lane_data[N_CELLS].term_neg ? -$signed(last_mag) : $signed(last_mag);
      total        = (SUM_W+1)'(lane_data[N_CELLS].sum) + (SUM_W+1)'(last_term);
      out_valid_in = out_adv ? lane_valid[N_CELLS] : out_valid_ff;
      value_in     = value_ff;
      if (out_adv) begin
         if (total > SAT_HI) begin
            value_in = SAT_HI[VALUE_W-1:0];
         end else if (total < SAT_LO) begin
            value_in = SAT_LO[VALUE_W-1:0];
         end else begin
            value_in = total[VALUE_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign rsp_bus.valid = out_valid_ff;
   assign rsp_bus.value = value_ff;

   // backpressure reaches the request side only with the output stalled
   `SCT_ASSERT_SAME(a_full_stall, clock, reset, !req_bus.ready, rsp_bus.valid && !rsp_bus.ready, "request stall without a stalled response")
   // a beat from the last cell shows up as a response next cycle
   `SCT_ASSERT_NEXT(a_last_beat, clock, reset, lane_valid[N_CELLS] && lane_ready[N_CELLS], rsp_bus.valid, "last cell beat lost")
   // a taken response with nothing behind it leaves the output empty
   `SCT_ASSERT_NEXT(a_drain, clock, reset, rsp_bus.valid && rsp_bus.ready && !lane_valid[N_CELLS], !rsp_bus.valid, "response repeated")

endmodule
